/* src/chc_pkg.sv */
// Shared types, constants and the arctangent table for the compass heading unit.
package chc_pkg;

    localparam int ANGLE_FRAC_BITS = 6;
    localparam int CORDIC_STEPS    = 24;
    localparam int PRESCALE        = 16;
    localparam int SAMPLE_W        = 16;
    localparam int DIFF_W          = SAMPLE_W + 1;
    localparam int VEC_W           = 36;
    localparam int ANG_W           = 32;
    localparam int STEP_W          = $clog2(CORDIC_STEPS);
    localparam int HEADING_W       = 15;

    localparam int FULL_TURN = 360 << ANGLE_FRAC_BITS;
    localparam int DEG_90    = 90 << ANGLE_FRAC_BITS;
    localparam int DEG_270   = 270 << ANGLE_FRAC_BITS;
    localparam int TURN_W    = $clog2(FULL_TURN + 1);
    localparam int PROD_W    = ANG_W + TURN_W;
    localparam int CALC_W    = (TURN_W > HEADING_W) ? TURN_W : HEADING_W;

    localparam logic [ANG_W-1:0] HALF_TURN = {1'b1, {(ANG_W-1){1'b0}}};

    typedef enum logic [1:0] {
        KIND_MEASURE    = 2'd0,
        KIND_CAL_FIRST  = 2'd1,
        KIND_CAL_SAMPLE = 2'd2,
        KIND_CAL_FINISH = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                      kind;
        logic signed [SAMPLE_W-1:0] x_raw;
        logic signed [SAMPLE_W-1:0] y_raw;
    } chc_in_t;

    typedef struct packed {
        logic [HEADING_W-1:0]       heading;
        logic                       heading_valid;
        logic signed [SAMPLE_W-1:0] x_offset_now;
        logic signed [SAMPLE_W-1:0] y_offset_now;
    } chc_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_SCALE,
        ST_REMAP,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                     start;
        logic signed [DIFF_W-1:0] d;
        logic signed [DIFF_W-1:0] e;
    } cordic_req_t;

    typedef struct packed {
        logic             done;
        logic [ANG_W-1:0] angle;
    } cordic_rsp_t;

    // atan(2^-i) in turns, scaled by 2^32, rounded to nearest
    function automatic logic [ANG_W-1:0] atan_turn(input logic [STEP_W-1:0] idx);
        logic [ANG_W-1:0] t;
        case (idx)
            5'd0:    t = 32'h2000_0000;
            5'd1:    t = 32'h12E4_051E;
            5'd2:    t = 32'h09FB_385B;
            5'd3:    t = 32'h0511_11D4;
            5'd4:    t = 32'h028B_0D43;
            5'd5:    t = 32'h0145_D7E1;
            5'd6:    t = 32'h00A2_F61E;
            5'd7:    t = 32'h0051_7C55;
            5'd8:    t = 32'h0028_BE53;
            5'd9:    t = 32'h0014_5F2F;
            5'd10:   t = 32'h000A_2F98;
            5'd11:   t = 32'h0005_17CC;
            5'd12:   t = 32'h0002_8BE6;
            5'd13:   t = 32'h0001_45F3;
            5'd14:   t = 32'h0000_A2FA;
            5'd15:   t = 32'h0000_517D;
            5'd16:   t = 32'h0000_28BE;
            5'd17:   t = 32'h0000_145F;
            5'd18:   t = 32'h0000_0A30;
            5'd19:   t = 32'h0000_0518;
            5'd20:   t = 32'h0000_028C;
            5'd21:   t = 32'h0000_0146;
            5'd22:   t = 32'h0000_00A3;
            5'd23:   t = 32'h0000_0051;
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

/* src/compass_heading_with_offset_calibration_unit.sv */
// Top level: compass heading with hard-iron offset calibration.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------------
//  s_      | in  | s_valid / s_ready  | kind, x_raw, y_raw
//  m_      | out | m_valid / m_ready  | heading, heading_valid, x_offset_now, y_offset_now
//
// A measure transaction runs from accept to the next accept through a load step,
// 24 CORDIC micro-rotations on the shared shift/add unit, then done, scale
// (one 32 x 15 multiply), remap and output register load. Calibration transactions
// go straight to output. Synchronous active-low reset clears the sequencer,
// min/max tracking and offsets to zero. s_ready is high only in idle, but a result
// parked in the output register does not hold off the next input transaction;
// only a second result waiting on m_ready stalls the sequencer in its output state.
module compass_heading_with_offset_calibration_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  chc_pkg::chc_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output chc_pkg::chc_out_t m_data
);
    import chc_pkg::*;

    state_t state_reg, state_next;

    // calibration state
    logic signed [SAMPLE_W-1:0] x_low_reg, x_low_next;
    logic signed [SAMPLE_W-1:0] x_high_reg, x_high_next;
    logic signed [SAMPLE_W-1:0] y_low_reg, y_low_next;
    logic signed [SAMPLE_W-1:0] y_high_reg, y_high_next;
    logic signed [SAMPLE_W-1:0] x_offset_reg, x_offset_next;
    logic signed [SAMPLE_W-1:0] y_offset_reg, y_offset_next;

    // measure datapath
    logic                 zero_reg, zero_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [HEADING_W-1:0] heading_reg, heading_next;
    logic                 hvalid_reg, hvalid_next;

    // output register
    logic     m_valid_reg, m_valid_next;
    chc_out_t m_data_reg, m_data_next;

    cordic_req_t cordic_req;
    cordic_rsp_t cordic_rsp;

    logic                     s_acc, out_free, is_measure;
    logic signed [DIFF_W-1:0] d_diff, e_diff;
    logic [TURN_W-1:0]        a_raw, a_wrap;
    logic [CALC_W-1:0]        a_calc, heading_calc;

    // (a + b) / 2, truncated toward zero
    function automatic logic signed [SAMPLE_W-1:0] midpoint(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b
    );
        logic signed [DIFF_W-1:0] sum;
        logic signed [DIFF_W-1:0] adj;
        sum = DIFF_W'(a) + DIFF_W'(b);
        adj = sum + {{(DIFF_W-1){1'b0}}, sum[DIFF_W-1]};
        return adj[DIFF_W-1:1];
    endfunction

    assign s_acc      = s_valid && s_ready;
    assign is_measure = (s_data.kind == KIND_MEASURE);
    assign out_free   = !m_valid_reg || m_ready;

    // offset removal: exact 17-bit differences
    assign d_diff = DIFF_W'(s_data.x_raw) - DIFF_W'(x_offset_reg);
    assign e_diff = DIFF_W'(s_data.y_raw) - DIFF_W'(y_offset_reg);

    chc_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cordic_req),
        .rsp     (cordic_rsp)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    state_next = is_measure ? ST_CORDIC : ST_OUT;
                end
            end
            ST_CORDIC: begin
                if (cordic_rsp.done) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:  state_next = ST_REMAP;
            ST_REMAP:  state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready          = 1'b0;
        cordic_req.start = 1'b0;
        cordic_req.d     = d_diff;
        cordic_req.e     = e_diff;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready          = 1'b1;
                cordic_req.start = s_valid && is_measure;
            end
            default: ;
        endcase
    end

    // angle scaling and remap
    assign a_raw  = prod_reg[PROD_W-1:ANG_W];
    assign a_wrap = (zero_reg || (a_raw >= TURN_W'(FULL_TURN))) ? '0 : a_raw;
    assign a_calc = CALC_W'(a_wrap);
    assign heading_calc = (a_calc <= CALC_W'(DEG_270)) ? (a_calc + CALC_W'(DEG_90))
                                                       : (a_calc - CALC_W'(DEG_270));

    always_comb begin
        x_low_next    = x_low_reg;
        x_high_next   = x_high_reg;
        y_low_next    = y_low_reg;
        y_high_next   = y_high_reg;
        x_offset_next = x_offset_reg;
        y_offset_next = y_offset_reg;
        zero_next     = zero_reg;
        prod_next     = prod_reg;
        heading_next  = heading_reg;
        hvalid_next   = hvalid_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        if (s_acc) begin
            heading_next = '0;
            hvalid_next  = 1'b0;
            case (s_data.kind)
                KIND_MEASURE: begin
                    // zero vector has no direction: forced to angle 0
                    zero_next   = (d_diff == '0) && (e_diff == '0);
                    hvalid_next = 1'b1;
                end
                KIND_CAL_FIRST: begin
                    x_low_next  = s_data.x_raw;
                    x_high_next = s_data.x_raw;
                    y_low_next  = s_data.y_raw;
                    y_high_next = s_data.y_raw;
                end
                KIND_CAL_SAMPLE: begin
                    if (s_data.x_raw < x_low_reg)  x_low_next  = s_data.x_raw;
                    if (s_data.x_raw > x_high_reg) x_high_next = s_data.x_raw;
                    if (s_data.y_raw < y_low_reg)  y_low_next  = s_data.y_raw;
                    if (s_data.y_raw > y_high_reg) y_high_next = s_data.y_raw;
                end
                default: begin
                    x_offset_next = midpoint(x_low_reg, x_high_reg);
                    y_offset_next = midpoint(y_low_reg, y_high_reg);
                end
            endcase
        end

        // binary angle times full-scale degrees, rounded at bit 32
        if (state_reg == ST_SCALE) begin
            prod_next = ({{TURN_W{1'b0}}, cordic_rsp.angle} * PROD_W'(FULL_TURN))
                        + PROD_W'(HALF_TURN);
        end

        if (state_reg == ST_REMAP) begin
            heading_next = heading_calc[HEADING_W-1:0];
        end

        if ((state_reg == ST_OUT) && out_free) begin
            m_valid_next               = 1'b1;
            m_data_next.heading        = heading_reg;
            m_data_next.heading_valid  = hvalid_reg;
            m_data_next.x_offset_now   = x_offset_reg;
            m_data_next.y_offset_now   = y_offset_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            x_low_reg    <= '0;
            x_high_reg   <= '0;
            y_low_reg    <= '0;
            y_high_reg   <= '0;
            x_offset_reg <= '0;
            y_offset_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            x_low_reg    <= x_low_next;
            x_high_reg   <= x_high_next;
            y_low_reg    <= y_low_next;
            y_high_reg   <= y_high_next;
            x_offset_reg <= x_offset_next;
            y_offset_reg <= y_offset_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        zero_reg    <= zero_next;
        prod_reg    <= prod_next;
        heading_reg <= heading_next;
        hvalid_reg  <= hvalid_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // a measure transaction always hands off to the CORDIC wait state
    a_measure_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.kind == KIND_MEASURE) |=> state_reg == ST_CORDIC)
        else $error("measure transaction did not start the CORDIC");

    // the CORDIC must only finish while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        cordic_rsp.done |-> state_reg == ST_CORDIC)
        else $error("CORDIC done outside of wait state");

    // calibration tracking keeps low at or below high
    a_minmax_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (x_low_reg <= x_high_reg) && (y_low_reg <= y_high_reg))
        else $error("calibration min/max out of order");

    // non-measure results carry a zero heading
    a_zero_heading: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.heading_valid |-> m_data.heading == '0)
        else $error("nonzero heading on calibration result");
`endif

endmodule

/* src/chc_cordic.sv */
// Iterative vectoring CORDIC: one shift/add micro-rotation per cycle.
module chc_cordic (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  chc_pkg::cordic_req_t req,
    output chc_pkg::cordic_rsp_t rsp
);
    import chc_pkg::*;

    logic signed [VEC_W-1:0] x_reg, x_next;
    logic signed [VEC_W-1:0] y_reg, y_next;
    logic [ANG_W-1:0]        z_reg, z_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;

    logic signed [VEC_W-1:0] d_ext, e_ext, xs, ys;
    logic [ANG_W-1:0]        t_step;
    logic                    last_step;

    // prescale by 2^PRESCALE
    assign d_ext = {{(VEC_W-DIFF_W){req.d[DIFF_W-1]}}, req.d} <<< PRESCALE;
    assign e_ext = {{(VEC_W-DIFF_W){req.e[DIFF_W-1]}}, req.e} <<< PRESCALE;

    // arithmetic shifts floor toward minus infinity
    assign xs        = x_reg >>> step_reg;
    assign ys        = y_reg >>> step_reg;
    assign t_step    = atan_turn(step_reg);
    assign last_step = (step_reg == STEP_W'(CORDIC_STEPS - 1));

    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            // left half-plane: rotate by a half turn first
            if (req.d[DIFF_W-1]) begin
                x_next = -d_ext;
                y_next = -e_ext;
                z_next = HALF_TURN;
            end else begin
                x_next = d_ext;
                y_next = e_ext;
                z_next = '0;
            end
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!y_reg[VEC_W-1]) begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + t_step;
            end else begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - t_step;
            end
            step_next = step_reg + 1'b1;
            if (last_step) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.angle = z_reg;

endmodule
